/* sv/cds_pkg.sv */
package cds_pkg;

  typedef enum logic [2:0] {
    REQ_TICK      = 3'd0,
    REQ_NEXT      = 3'd1,
    REQ_LEAVE     = 3'd2,
    REQ_STEP_FWD  = 3'd3,
    REQ_STEP_BACK = 3'd4,
    REQ_BULK_FWD  = 3'd5,
    REQ_BULK_BACK = 3'd6,
    REQ_NONE      = 3'd7
  } req_e;

  typedef enum logic [1:0] {
    FIELD_DAY   = 2'd0,
    FIELD_MONTH = 2'd1,
    FIELD_YEAR  = 2'd2,
    FIELD_SPARE = 2'd3
  } field_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_STEP,
    S_HOLD
  } state_e;

  localparam int unsigned BaseYear   = 2020;
  localparam int unsigned YearSpan   = 100;
  localparam int unsigned NumMonths  = 12;
  localparam int unsigned BulkDays   = 7;
  localparam int unsigned BulkOther  = 3;
  // offset of the one century year in range (2100), which is not a leap year
  localparam logic [6:0] CenturyOff  = 7'(2100 - BaseYear);

  localparam logic [4:0] MonthLen [NumMonths] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  localparam logic [2:0] BulkDaysM1  = 3'(BulkDays - 1);
  localparam logic [2:0] BulkOtherM1 = 3'(BulkOther - 1);

  typedef struct packed {
    logic capture;   // latch the incoming word
    logic apply;     // non-step effect: enter, tick, next field, leave
    logic step;      // one single step of the selected field
    logic publish;   // load the output register
  } cmd_t;

  typedef struct packed {
    logic       step_req;   // latched request is a field step
    logic [2:0] steps_m1;   // number of single steps minus one
    logic       out_free;   // output register can take a word this cycle
  } status_t;

endpackage

/* sv/cds_ctrl.sv */
module cds_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  cds_pkg::status_t st_i,
  output cds_pkg::cmd_t    cmd_o
);

  cds_pkg::state_e state_q, state_d;
  logic [2:0]      cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cds_pkg::S_IDLE;
      cnt_q   <= 3'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      cds_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = cds_pkg::S_DECODE;
        end
      end
      cds_pkg::S_DECODE: begin
        if (st_i.step_req) begin
          cnt_d   = st_i.steps_m1;
          state_d = cds_pkg::S_STEP;
        end else begin
          cmd_o.apply = 1'b1;
          state_d     = cds_pkg::S_HOLD;
        end
      end
      cds_pkg::S_STEP: begin
        cmd_o.step = 1'b1;
        if (cnt_q == 3'd0) begin
          state_d = cds_pkg::S_HOLD;
        end else begin
          cnt_d = cnt_q - 3'd1;
        end
      end
      cds_pkg::S_HOLD: begin
        if (st_i.out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = cds_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = cds_pkg::S_IDLE;
      end
    endcase
  end

  a_step_only_for_step_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cds_pkg::S_STEP) |-> st_i.step_req)
    else $error("step issued for a non-step request");

  a_step_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cds_pkg::S_STEP) |-> (cnt_q <= cds_pkg::BulkDaysM1))
    else $error("step count beyond bulk day count");

  a_hold_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cds_pkg::S_HOLD && !st_i.out_free) |=> (state_q == cds_pkg::S_HOLD))
    else $error("result dropped while output register busy");

endmodule

/* sv/cds_dp.sv */
module cds_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cds_pkg::cmd_t    cmd_i,
  output cds_pkg::status_t st_o,
  input  logic [2:0]       req_type_i,
  input  logic [4:0]       now_day_i,
  input  logic [3:0]       now_month_i,
  input  logic [6:0]       now_year_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             browsing_o,
  output logic [1:0]       field_sel_o,
  output logic [4:0]       shown_day_o,
  output logic [3:0]       shown_month_o,
  output logic [6:0]       shown_year_o,
  output logic             day_visible_o,
  output logic             month_visible_o,
  output logic             year_visible_o
);

  function automatic logic [4:0] days_in_month(logic [3:0] m, logic [6:0] y);
    logic leap;
    leap = (y[1:0] == 2'b00) && (y != cds_pkg::CenturyOff);
    if (m < 4'd1 || m > 4'(cds_pkg::NumMonths)) begin
      days_in_month = 5'd31;
    end else if (m == 4'd2) begin
      days_in_month = leap ? 5'd29 : 5'd28;
    end else begin
      days_in_month = cds_pkg::MonthLen[m - 4'd1];
    end
  endfunction

  // latched request word
  logic [2:0] req_q;
  logic [4:0] nday_q;
  logic [3:0] nmon_q;
  logic [6:0] nyear_q;

  // browser state
  logic       active_q, active_d;
  logic [1:0] field_q, field_d;
  logic       blink_q, blink_d;
  logic [4:0] day_q, day_d;
  logic [3:0] month_q, month_d;
  logic [6:0] year_q, year_d;

  // output register
  logic       out_valid_q;
  logic       o_browsing_q;
  logic [1:0] o_field_q;
  logic [4:0] o_day_q;
  logic [3:0] o_month_q;
  logic [6:0] o_year_q;
  logic       o_dvis_q, o_mvis_q, o_yvis_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q   <= req_type_i;
      nday_q  <= now_day_i;
      nmon_q  <= now_month_i;
      nyear_q <= now_year_i;
    end
  end

  // status
  logic fwd;
  logic is_step_code;
  logic is_bulk;

  always_comb begin
    fwd = (req_q == cds_pkg::REQ_STEP_FWD) || (req_q == cds_pkg::REQ_BULK_FWD);
    is_step_code = (req_q == cds_pkg::REQ_STEP_FWD) || (req_q == cds_pkg::REQ_STEP_BACK) ||
                   (req_q == cds_pkg::REQ_BULK_FWD) || (req_q == cds_pkg::REQ_BULK_BACK);
    is_bulk = (req_q == cds_pkg::REQ_BULK_FWD) || (req_q == cds_pkg::REQ_BULK_BACK);
    st_o.step_req = active_q && is_step_code;
    if (!is_bulk) begin
      st_o.steps_m1 = 3'd0;
    end else if (field_q == cds_pkg::FIELD_DAY) begin
      st_o.steps_m1 = cds_pkg::BulkDaysM1;
    end else begin
      st_o.steps_m1 = cds_pkg::BulkOtherM1;
    end
    st_o.out_free = !out_valid_q || !out_stall_i;
  end

  // single-step unit
  logic [7:0] y_plus;
  logic [6:0] year_inc, year_dec;
  logic [3:0] m_plus;
  logic [3:0] mon_inc, mon_dec;
  logic [6:0] yr_of_minc, yr_of_mdec;
  logic [5:0] d_plus;
  logic [4:0] md_cur;
  logic [4:0] step_day;
  logic [3:0] step_mon;
  logic [6:0] step_year;

  always_comb begin
    y_plus   = {1'b0, year_q} + 8'd1;
    year_inc = (y_plus >= 8'(cds_pkg::YearSpan)) ? 7'(y_plus - 8'(cds_pkg::YearSpan))
                                                 : y_plus[6:0];
    year_dec = (year_q == 7'd0) ? 7'(cds_pkg::YearSpan - 1) : year_q - 7'd1;

    m_plus = month_q + 4'd1;
    if (m_plus > 4'(cds_pkg::NumMonths) || m_plus == 4'd0) begin
      mon_inc    = 4'd1;
      yr_of_minc = year_inc;
    end else begin
      mon_inc    = m_plus;
      yr_of_minc = year_q;
    end
    if (month_q > 4'd1) begin
      mon_dec    = month_q - 4'd1;
      yr_of_mdec = year_q;
    end else begin
      mon_dec    = 4'(cds_pkg::NumMonths);
      yr_of_mdec = year_dec;
    end

    d_plus = {1'b0, day_q} + 6'd1;
    md_cur = days_in_month(month_q, year_q);

    step_day  = day_q;
    step_mon  = month_q;
    step_year = year_q;
    case (field_q)
      cds_pkg::FIELD_DAY: begin
        if (fwd) begin
          if (d_plus > {1'b0, md_cur}) begin
            step_day  = 5'd1;
            step_mon  = mon_inc;
            step_year = yr_of_minc;
          end else begin
            step_day = d_plus[4:0];
          end
        end else begin
          if (day_q > 5'd1) begin
            step_day = day_q - 5'd1;
          end else begin
            step_mon  = mon_dec;
            step_year = yr_of_mdec;
            step_day  = days_in_month(mon_dec, yr_of_mdec);
          end
        end
      end
      cds_pkg::FIELD_MONTH: begin
        if (fwd) begin
          step_mon  = mon_inc;
          step_year = yr_of_minc;
        end else begin
          step_mon  = mon_dec;
          step_year = yr_of_mdec;
        end
      end
      default: begin
        step_year = fwd ? year_inc : year_dec;
      end
    endcase
  end

  // state update
  always_comb begin
    active_d = active_q;
    field_d  = field_q;
    blink_d  = blink_q;
    day_d    = day_q;
    month_d  = month_q;
    year_d   = year_q;
    if (cmd_i.step) begin
      day_d   = step_day;
      month_d = step_mon;
      year_d  = step_year;
    end else if (cmd_i.apply) begin
      if (req_q == cds_pkg::REQ_BULK_FWD && !active_q) begin
        active_d = 1'b1;
        day_d    = nday_q;
        month_d  = nmon_q;
        year_d   = nyear_q;
        blink_d  = 1'b1;
        field_d  = cds_pkg::FIELD_DAY;
      end else if (active_q) begin
        case (req_q)
          cds_pkg::REQ_TICK: begin
            blink_d = !blink_q;
          end
          cds_pkg::REQ_NEXT: begin
            field_d = (field_q >= cds_pkg::FIELD_YEAR) ? cds_pkg::FIELD_DAY : field_q + 2'd1;
          end
          cds_pkg::REQ_LEAVE: begin
            active_d = 1'b0;
            blink_d  = 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      field_q  <= 2'd0;
      blink_q  <= 1'b0;
      day_q    <= 5'd0;
      month_q  <= 4'd0;
      year_q   <= 7'd0;
    end else begin
      active_q <= active_d;
      field_q  <= field_d;
      blink_q  <= blink_d;
      day_q    <= day_d;
      month_q  <= month_d;
      year_q   <= year_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.publish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      o_browsing_q <= active_q;
      o_field_q    <= field_q;
      o_day_q      <= day_q;
      o_month_q    <= month_q;
      o_year_q     <= year_q;
      o_dvis_q     <= !(active_q && field_q == cds_pkg::FIELD_DAY && !blink_q);
      o_mvis_q     <= !(active_q && field_q == cds_pkg::FIELD_MONTH && !blink_q);
      o_yvis_q     <= !(active_q && field_q >= cds_pkg::FIELD_YEAR && !blink_q);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign browsing_o      = o_browsing_q;
  assign field_sel_o     = o_field_q;
  assign shown_day_o     = o_day_q;
  assign shown_month_o   = o_month_q;
  assign shown_year_o    = o_year_q;
  assign day_visible_o   = o_dvis_q;
  assign month_visible_o = o_mvis_q;
  assign year_visible_o  = o_yvis_q;

  a_field_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    field_q != cds_pkg::FIELD_SPARE)
    else $error("field index reached unused code");

  a_step_keeps_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> active_q && (active_d == active_q))
    else $error("field step while not browsing");

endmodule

/* sv/calendar_date_scroller.sv */
// Calendar date browser. A word on the input channel is a request (tick, next field,
// leave, step forward/back, enter or bulk forward, bulk back) plus the current clock
// date, which is used only when entering; every request returns exactly one word with
// the browsed date, selected field and blink visibility flags. A request is captured,
// then decoded, then a field step runs as single steps (1 for a plain step, 7 for a
// day bulk step, 3 for a month or year bulk step) in the shared step unit, and last the
// output register is loaded; a request without a step skips the step unit, and loading
// waits while the output side stalls a pending result.
// A new request is taken while the previous result still waits in the output register.
module calendar_date_scroller (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] req_type_i,
  input  logic [4:0] now_day_i,
  input  logic [3:0] now_month_i,
  input  logic [6:0] now_year_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       browsing_o,
  output logic [1:0] field_sel_o,
  output logic [4:0] shown_day_o,
  output logic [3:0] shown_month_o,
  output logic [6:0] shown_year_o,
  output logic       day_visible_o,
  output logic       month_visible_o,
  output logic       year_visible_o
);

  cds_pkg::cmd_t    cmd;
  cds_pkg::status_t st;

  cds_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  cds_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .st_o            (st),
    .req_type_i      (req_type_i),
    .now_day_i       (now_day_i),
    .now_month_i     (now_month_i),
    .now_year_i      (now_year_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .browsing_o      (browsing_o),
    .field_sel_o     (field_sel_o),
    .shown_day_o     (shown_day_o),
    .shown_month_o   (shown_month_o),
    .shown_year_o    (shown_year_o),
    .day_visible_o   (day_visible_o),
    .month_visible_o (month_visible_o),
    .year_visible_o  (year_visible_o)
  );

endmodule

/* sim/calendar_date_scroller_tb.sv */
module calendar_date_scroller_tb;

  typedef struct packed {
    logic             browsing;
    cds_pkg::field_e  field;
    logic [4:0]       day;
    logic [3:0]       month;
    logic [6:0]       year;
    logic             day_vis;
    logic             month_vis;
    logic             year_vis;
  } date_view_t;

  typedef struct {
    cds_pkg::req_e req;
    logic [4:0]    day;
    logic [3:0]    month;
    logic [6:0]    year;
    bit            typed;
    date_view_t    want;
  } script_row_t;

  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned ItemsPerPhase = 500;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [2:0] req_type_i = cds_pkg::REQ_TICK;
  logic [4:0] now_day_i = '0;
  logic [3:0] now_month_i = '0;
  logic [6:0] now_year_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic       browsing_o;
  logic [1:0] field_sel_o;
  logic [4:0] shown_day_o;
  logic [3:0] shown_month_o;
  logic [6:0] shown_year_o;
  logic       day_visible_o;
  logic       month_visible_o;
  logic       year_visible_o;

  calendar_date_scroller dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .now_day_i      (now_day_i),
    .now_month_i    (now_month_i),
    .now_year_i     (now_year_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .browsing_o     (browsing_o),
    .field_sel_o    (field_sel_o),
    .shown_day_o    (shown_day_o),
    .shown_month_o  (shown_month_o),
    .shown_year_o   (shown_year_o),
    .day_visible_o  (day_visible_o),
    .month_visible_o(month_visible_o),
    .year_visible_o (year_visible_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // browser state as the block should hold it
  logic            br_active;
  cds_pkg::field_e br_field;
  logic            br_blink;
  logic [4:0]      br_day;
  logic [3:0]      br_month;
  logic [6:0]      br_year;

  date_view_t  expected_views[$];
  script_row_t script[$];
  int unsigned mismatches = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned quiet_cycles = 0;

  function automatic int unsigned days_in(input logic [3:0] m, input logic [6:0] y);
    int unsigned full;
    full = int'(y) + 2020;
    case (m)
      4'd2: return ((full % 4 == 0) && ((full % 100 != 0) || (full % 400 == 0))) ? 29 : 28;
      4'd4, 4'd6, 4'd9, 4'd11: return 30;
      default: return 31;  // includes months outside 1..12
    endcase
  endfunction

  function automatic void year_inc();
    br_year = 7'((int'(br_year) + 1) % 100);
  endfunction

  function automatic void year_dec();
    br_year = (br_year == 7'd0) ? 7'd99 : br_year - 7'd1;
  endfunction

  function automatic void month_inc();
    br_month = br_month + 4'd1;
    if (br_month > 4'd12 || br_month == 4'd0) begin
      br_month = 4'd1;
      year_inc();
    end
  endfunction

  function automatic void month_dec();
    if (br_month > 4'd1) begin
      br_month = br_month - 4'd1;
    end else begin
      br_month = 4'd12;
      year_dec();
    end
  endfunction

  function automatic void day_inc();
    int unsigned d;
    d = int'(br_day) + 1;
    if (d > days_in(br_month, br_year)) begin
      br_day = 5'd1;
      month_inc();
    end else begin
      br_day = 5'(d);
    end
  endfunction

  function automatic void day_dec();
    if (br_day > 5'd1) begin
      br_day = br_day - 5'd1;
    end else begin
      month_dec();
      br_day = 5'(days_in(br_month, br_year));
    end
  endfunction

  function automatic void move_field(input bit fwd, input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      case (br_field)
        cds_pkg::FIELD_DAY: if (fwd) day_inc(); else day_dec();
        cds_pkg::FIELD_MONTH: if (fwd) month_inc(); else month_dec();
        default: if (fwd) year_inc(); else year_dec();
      endcase
    end
  endfunction

  function automatic date_view_t browse_request(input cds_pkg::req_e r, input logic [4:0] d,
                                                input logic [3:0] m, input logic [6:0] y);
    int unsigned bulk;
    date_view_t  v;
    if (r == cds_pkg::REQ_BULK_FWD && !br_active) begin
      br_active = 1'b1;
      br_day    = d;
      br_month  = m;
      br_year   = y;
      br_blink  = 1'b1;
      br_field  = cds_pkg::FIELD_DAY;
    end else if (br_active) begin
      bulk = (br_field == cds_pkg::FIELD_DAY) ? 7 : 3;
      case (r)
        cds_pkg::REQ_TICK: br_blink = ~br_blink;
        cds_pkg::REQ_NEXT: begin
          br_field = (br_field == cds_pkg::FIELD_YEAR || br_field == cds_pkg::FIELD_SPARE) ?
                     cds_pkg::FIELD_DAY : cds_pkg::field_e'(br_field + 2'd1);
        end
        cds_pkg::REQ_LEAVE: begin
          br_active = 1'b0;
          br_blink  = 1'b0;
        end
        cds_pkg::REQ_STEP_FWD: move_field(1'b1, 1);
        cds_pkg::REQ_STEP_BACK: move_field(1'b0, 1);
        cds_pkg::REQ_BULK_FWD: move_field(1'b1, bulk);
        cds_pkg::REQ_BULK_BACK: move_field(1'b0, bulk);
        default: ;
      endcase
    end
    v.browsing  = br_active;
    v.field     = br_field;
    v.day       = br_day;
    v.month     = br_month;
    v.year      = br_year;
    v.day_vis   = !(br_active && br_field == cds_pkg::FIELD_DAY && !br_blink);
    v.month_vis = !(br_active && br_field == cds_pkg::FIELD_MONTH && !br_blink);
    v.year_vis  = !(br_active && br_field >= cds_pkg::FIELD_YEAR && !br_blink);
    return v;
  endfunction

  function automatic date_view_t view(input logic b, input cds_pkg::field_e f,
                                      input logic [4:0] d, input logic [3:0] m,
                                      input logic [6:0] y,
                                      input logic dv, input logic mv, input logic yv);
    return '{b, f, d, m, y, dv, mv, yv};
  endfunction

  function automatic string fmt_view(input date_view_t v);
    return $sformatf("browsing=%0d field=%0d day=%0d month=%0d year=%0d vis=%b%b%b",
                     v.browsing, v.field, v.day, v.month, v.year,
                     v.day_vis, v.month_vis, v.year_vis);
  endfunction

  task automatic add_row(input cds_pkg::req_e r, input logic [4:0] d, input logic [3:0] m,
                         input logic [6:0] y, input bit typed, input date_view_t want);
    script.push_back('{r, d, m, y, typed, want});
  endtask

  task automatic send_word(input cds_pkg::req_e r, input logic [4:0] d, input logic [3:0] m,
                           input logic [6:0] y, input bit typed, input date_view_t want);
    date_view_t v;
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= r;
    now_day_i   <= d;
    now_month_i <= m;
    now_year_i  <= y;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    v = browse_request(r, d, m, y);
    expected_views.push_back(typed ? want : v);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_views.size() != 0) @(posedge clk_i);
  endtask

  function automatic cds_pkg::req_e pick_request();
    int unsigned p;
    p = $urandom_range(99);
    if (!br_active) begin
      return (p < 75) ? cds_pkg::REQ_BULK_FWD : cds_pkg::req_e'(3'($urandom_range(7)));
    end
    if (p < 14) return cds_pkg::REQ_TICK;
    if (p < 28) return cds_pkg::REQ_NEXT;
    if (p < 32) return cds_pkg::REQ_LEAVE;
    if (p < 52) return cds_pkg::REQ_STEP_FWD;
    if (p < 72) return cds_pkg::REQ_STEP_BACK;
    if (p < 84) return cds_pkg::REQ_BULK_FWD;
    if (p < 97) return cds_pkg::REQ_BULK_BACK;
    return cds_pkg::REQ_NONE;
  endfunction

  // result side: check each accepted word, then pick next stall
  always @(posedge clk_i) begin
    date_view_t got;
    date_view_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{browsing_o, cds_pkg::field_e'(field_sel_o), shown_day_o, shown_month_o,
              shown_year_o, day_visible_o, month_visible_o, year_visible_o};
      if (expected_views.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: %s", fmt_view(got));
      end else begin
        want = expected_views.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected %s", fmt_view(want));
            $display("          actual   %s", fmt_view(got));
          end
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("calendar_date_scroller_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    date_view_t    none_v;
    cds_pkg::req_e r;
    logic [4:0]    d;
    logic [3:0]    m;
    logic [6:0]    y;
    none_v = '0;
    br_active = 1'b0;
    br_field  = cds_pkg::FIELD_DAY;
    br_blink  = 1'b0;
    br_day    = '0;
    br_month  = '0;
    br_year   = '0;

    // ignored while idle: everything stays at its reset value
    add_row(cds_pkg::REQ_TICK, 5'd0, 4'd0, 7'd0, 1'b1,
            view(1'b0, cds_pkg::FIELD_DAY, 5'd0, 4'd0, 7'd0, 1'b1, 1'b1, 1'b1));
    add_row(cds_pkg::REQ_STEP_FWD, 5'd31, 4'd15, 7'd127, 1'b1,
            view(1'b0, cds_pkg::FIELD_DAY, 5'd0, 4'd0, 7'd0, 1'b1, 1'b1, 1'b1));
    add_row(cds_pkg::REQ_NONE, 5'd31, 4'd15, 7'd127, 1'b1,
            view(1'b0, cds_pkg::FIELD_DAY, 5'd0, 4'd0, 7'd0, 1'b1, 1'b1, 1'b1));
    // enter on the last day of the range, then wrap the year both ways
    add_row(cds_pkg::REQ_BULK_FWD, 5'd31, 4'd12, 7'd99, 1'b1,
            view(1'b1, cds_pkg::FIELD_DAY, 5'd31, 4'd12, 7'd99, 1'b1, 1'b1, 1'b1));
    add_row(cds_pkg::REQ_STEP_FWD, 5'd0, 4'd0, 7'd0, 1'b1,
            view(1'b1, cds_pkg::FIELD_DAY, 5'd1, 4'd1, 7'd0, 1'b1, 1'b1, 1'b1));
    add_row(cds_pkg::REQ_STEP_BACK, 5'd0, 4'd0, 7'd0, 1'b1,
            view(1'b1, cds_pkg::FIELD_DAY, 5'd31, 4'd12, 7'd99, 1'b1, 1'b1, 1'b1));
    add_row(cds_pkg::REQ_TICK, 5'd0, 4'd0, 7'd0, 1'b1,
            view(1'b1, cds_pkg::FIELD_DAY, 5'd31, 4'd12, 7'd99, 1'b0, 1'b1, 1'b1));
    add_row(cds_pkg::REQ_NEXT, 5'd0, 4'd0, 7'd0, 1'b1,
            view(1'b1, cds_pkg::FIELD_MONTH, 5'd31, 4'd12, 7'd99, 1'b1, 1'b0, 1'b1));
    add_row(cds_pkg::REQ_BULK_BACK, 5'd0, 4'd0, 7'd0, 1'b1,
            view(1'b1, cds_pkg::FIELD_MONTH, 5'd31, 4'd9, 7'd99, 1'b1, 1'b0, 1'b1));
    add_row(cds_pkg::REQ_NEXT, 5'd0, 4'd0, 7'd0, 1'b1,
            view(1'b1, cds_pkg::FIELD_YEAR, 5'd31, 4'd9, 7'd99, 1'b1, 1'b1, 1'b0));
    add_row(cds_pkg::REQ_BULK_FWD, 5'd0, 4'd0, 7'd0, 1'b1,
            view(1'b1, cds_pkg::FIELD_YEAR, 5'd31, 4'd9, 7'd2, 1'b1, 1'b1, 1'b0));
    add_row(cds_pkg::REQ_STEP_BACK, 5'd0, 4'd0, 7'd0, 1'b1,
            view(1'b1, cds_pkg::FIELD_YEAR, 5'd31, 4'd9, 7'd1, 1'b1, 1'b1, 1'b0));
    add_row(cds_pkg::REQ_TICK, 5'd0, 4'd0, 7'd0, 1'b1,
            view(1'b1, cds_pkg::FIELD_YEAR, 5'd31, 4'd9, 7'd1, 1'b1, 1'b1, 1'b1));
    add_row(cds_pkg::REQ_NEXT, 5'd0, 4'd0, 7'd0, 1'b0, none_v);
    add_row(cds_pkg::REQ_NONE, 5'd0, 4'd0, 7'd0, 1'b0, none_v);
    add_row(cds_pkg::REQ_LEAVE, 5'd0, 4'd0, 7'd0, 1'b1,
            view(1'b0, cds_pkg::FIELD_DAY, 5'd31, 4'd9, 7'd1, 1'b1, 1'b1, 1'b1));
    // leap day 2020, bulk day step across into March
    add_row(cds_pkg::REQ_BULK_FWD, 5'd29, 4'd2, 7'd0, 1'b0, none_v);
    add_row(cds_pkg::REQ_BULK_FWD, 5'd0, 4'd0, 7'd0, 1'b0, none_v);
    add_row(cds_pkg::REQ_LEAVE, 5'd0, 4'd0, 7'd0, 1'b0, none_v);
    // out-of-range load: day 0, month 0, year 127
    add_row(cds_pkg::REQ_BULK_FWD, 5'd0, 4'd0, 7'd127, 1'b0, none_v);
    add_row(cds_pkg::REQ_STEP_BACK, 5'd0, 4'd0, 7'd0, 1'b0, none_v);
    add_row(cds_pkg::REQ_LEAVE, 5'd0, 4'd0, 7'd0, 1'b0, none_v);
    // 2100 has no leap day
    add_row(cds_pkg::REQ_BULK_FWD, 5'd28, 4'd2, 7'd80, 1'b0, none_v);
    add_row(cds_pkg::REQ_STEP_FWD, 5'd0, 4'd0, 7'd0, 1'b0, none_v);
    add_row(cds_pkg::REQ_LEAVE, 5'd0, 4'd0, 7'd0, 1'b0, none_v);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      send_word(script[i].req, script[i].day, script[i].month, script[i].year,
                script[i].typed, script[i].want);
    end
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 58; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 58; end
        default: begin idle_pct = 29; stall_pct = 29; end
      endcase
      for (int n = 0; n < ItemsPerPhase; n++) begin
        r = pick_request();
        if ($urandom_range(9) == 0) begin
          d = 5'($urandom_range(31));
          m = 4'($urandom_range(15));
          y = 7'($urandom_range(127));
        end else begin
          d = 5'($urandom_range(31, 1));
          m = 4'($urandom_range(12, 1));
          y = 7'($urandom_range(99));
        end
        send_word(r, d, m, y, 1'b0, none_v);
      end
      // sender holds off until every word of this phase is back
      wait_drained();
    end

    stall_pct = 0;
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && expected_views.size() == 0) begin
      $display("calendar_date_scroller_tb: PASS");
    end else begin
      $display("calendar_date_scroller_tb: FAIL");
    end
    $finish;
  end

endmodule
